/* hdl/ordered_array_list_engine_macros.svh */
// ----------------------------------------------------------------------------
// Ordered array list engine assertion macros
// Concurrent assertion wrappers for the engine, empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ORDERED_ARRAY_LIST_ENGINE_MACROS_SVH
`define ORDERED_ARRAY_LIST_ENGINE_MACROS_SVH

`ifndef SYNTH
`define OALE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Assertion failed in ordered array list engine.");
`define OALE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Assertion failed in ordered array list engine.");
`else
`define OALE_ASSERT_IMPL(label, ante, cons)
`define OALE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* hdl/oale_pkg.sv */
// ----------------------------------------------------------------------------
// Ordered array list engine package
// Sizes, command and status codes, transfer types and helper functions.
// ----------------------------------------------------------------------------
package oale_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CAPACITY   = 16;

    localparam int POS_W = 5;
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [2:0] CMD_PUSH   = 3'd0;
    localparam logic [2:0] CMD_POP    = 3'd1;
    localparam logic [2:0] CMD_GET    = 3'd2;
    localparam logic [2:0] CMD_FIND   = 3'd3;
    localparam logic [2:0] CMD_DELETE = 3'd4;
    localparam logic [2:0] CMD_SET    = 3'd5;
    localparam logic [2:0] CMD_INSERT = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_MISS  = 2'd3;

    localparam logic [1:0] CELL_HOLD  = 2'd0;
    localparam logic [1:0] CELL_WRITE = 2'd1;
    localparam logic [1:0] CELL_UP    = 2'd2;
    localparam logic [1:0] CELL_DOWN  = 2'd3;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [4:0]  position;
        logic [31:0] new_value;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_value;
        logic [3:0]  found_index;
        logic [4:0]  live_count;
    } rsp_t;

    typedef struct packed {
        logic [1:0]            op;
        logic [CMP_W-1:0]      pos;
        logic [CMP_W-1:0]      count;
        logic [DATA_WIDTH-1:0] key;
    } cell_ctrl_t;

    function automatic logic [DATA_WIDTH-1:0] to_word(input logic [31:0] v);
        logic [63:0] w;
        w = {32'b0, v};
        return w[DATA_WIDTH-1:0];
    endfunction

    function automatic logic [31:0] from_word(input logic [DATA_WIDTH-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[31:0];
    endfunction

    function automatic logic [3:0] to_found(input logic [IDX_W-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[3:0];
    endfunction

    function automatic logic [4:0] to_live(input logic [CNT_W-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[4:0];
    endfunction

endpackage

/* hdl/oale_cell.sv */
// ----------------------------------------------------------------------------
// Ordered array list engine cell
// Holds one list word, takes a new word or a neighbor's word, and compares.
// ----------------------------------------------------------------------------
module oale_cell
    import oale_pkg::*;
(
    input  logic                  clk,
    input  cell_ctrl_t            ctrl,
    input  logic [CMP_W-1:0]      idx,
    input  logic [DATA_WIDTH-1:0] left,
    input  logic [DATA_WIDTH-1:0] right,
    output logic [DATA_WIDTH-1:0] value,
    output logic                  match,
    output logic [DATA_WIDTH-1:0] rd
);

    logic [DATA_WIDTH-1:0] value_reg;
    logic [DATA_WIDTH-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        case (ctrl.op)
            CELL_WRITE:
            begin
                if (idx == ctrl.pos)
                begin
                    value_next = ctrl.key;
                end
            end
            CELL_UP:
            begin
                if (idx == ctrl.pos)
                begin
                    value_next = ctrl.key;
                end
                else if (idx > ctrl.pos)
                begin
                    value_next = left;
                end
            end
            CELL_DOWN:
            begin
                if (idx >= ctrl.pos)
                begin
                    value_next = right;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign match = (idx < ctrl.count) && (value_reg == ctrl.key);
    assign rd    = (idx == ctrl.pos) ? value_reg : '0;

endmodule

/* hdl/ordered_array_list_engine.sv */
// ----------------------------------------------------------------------------
// Ordered array list engine
// Fixed-capacity ordered word list with push, pop, get, find, delete, set
// and insert commands, built as a row of storage cells.
// ----------------------------------------------------------------------------
// Each command transfer is handled by the row of cells, which shifts,
// writes and compares all entries in parallel, and the result is registered
// in an output stage, so a new command is taken every cycle unless a result
// is held stalled on the response channel.
`include "ordered_array_list_engine_macros.svh"

module ordered_array_list_engine
    import oale_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    logic                  accept;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;
    rsp_t                  rsp_reg;
    rsp_t                  rsp_next;
    cell_ctrl_t            ctrl;
    logic [1:0]            op;
    logic [CMP_W-1:0]      pos_w;
    logic [CMP_W-1:0]      cnt_w;
    logic                  full;
    logic [DATA_WIDTH-1:0] key;
    logic [DATA_WIDTH-1:0] cell_value [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_rd    [CAPACITY];
    logic [CAPACITY-1:0]   cell_match;
    logic [DATA_WIDTH-1:0] rd_word;
    logic [IDX_W-1:0]      hit_idx;

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    assign pos_w = CMP_W'(req.position);
    assign cnt_w = CMP_W'(count_reg);
    assign full  = (count_reg == CNT_W'(CAPACITY));
    assign key   = to_word(req.new_value);

    assign ctrl.op    = accept ? op : CELL_HOLD;
    assign ctrl.pos   = (req.cmd == CMD_PUSH) ? cnt_w : pos_w;
    assign ctrl.count = cnt_w;
    assign ctrl.key   = key;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] left_w;
            logic [DATA_WIDTH-1:0] right_w;
            if (gi == 0)
            begin : g_first
                assign left_w = '0;
            end
            else
            begin : g_mid_l
                assign left_w = cell_value[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_w = '0;
            end
            else
            begin : g_mid_r
                assign right_w = cell_value[gi+1];
            end
            oale_cell u_cell (
                .clk   (clk),
                .ctrl  (ctrl),
                .idx   (CMP_W'(gi)),
                .left  (left_w),
                .right (right_w),
                .value (cell_value[gi]),
                .match (cell_match[gi]),
                .rd    (cell_rd[gi])
            );
        end
    endgenerate

    always_comb
    begin
        rd_word = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_word = rd_word | cell_rd[i];
        end
    end

    always_comb
    begin
        hit_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (cell_match[i])
            begin
                hit_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        op                   = CELL_HOLD;
        count_next           = count_reg;
        rsp_next.status      = ST_OK;
        rsp_next.read_value  = '0;
        rsp_next.found_index = '0;
        case (req.cmd)
            CMD_PUSH:
            begin
                if (full)
                begin
                    rsp_next.status = ST_FULL;
                end
                else
                begin
                    op         = CELL_WRITE;
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_POP:
            begin
                if (count_reg == '0)
                begin
                    rsp_next.status = ST_RANGE;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            CMD_GET:
            begin
                if (pos_w >= cnt_w)
                begin
                    rsp_next.status = ST_RANGE;
                end
                else
                begin
                    rsp_next.read_value = from_word(rd_word);
                end
            end
            CMD_FIND:
            begin
                if (|cell_match)
                begin
                    rsp_next.found_index = to_found(hit_idx);
                end
                else
                begin
                    rsp_next.status = ST_MISS;
                end
            end
            CMD_DELETE:
            begin
                if (pos_w >= cnt_w)
                begin
                    rsp_next.status = ST_RANGE;
                end
                else
                begin
                    op         = CELL_DOWN;
                    count_next = count_reg - 1'b1;
                end
            end
            CMD_SET:
            begin
                if (pos_w >= cnt_w)
                begin
                    rsp_next.status = ST_RANGE;
                end
                else
                begin
                    op = CELL_WRITE;
                end
            end
            CMD_INSERT:
            begin
                if (pos_w > cnt_w)
                begin
                    rsp_next.status = ST_RANGE;
                end
                else if (full)
                begin
                    rsp_next.status = ST_FULL;
                end
                else
                begin
                    op         = CELL_UP;
                    count_next = count_reg + 1'b1;
                end
            end
            default:
            begin
                op = CELL_HOLD;
            end
        endcase
        rsp_next.live_count = to_live(count_next);
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `OALE_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `OALE_ASSERT_NEXT(a_rsp_follows, accept, rsp_valid)
    `OALE_ASSERT_NEXT(a_rsp_count, accept, rsp.live_count == to_live(count_reg))
    `OALE_ASSERT_NEXT(a_count_hold, !accept, $stable(count_reg))

endmodule
